// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pdu_pkg.sv =====
`default_nettype none

package pdu_pkg;

   localparam int MAX_INPUTS   = 64;
   localparam int WEIGHT_DEPTH = MAX_INPUTS + 1;
   localparam int IDX_W        = $clog2(MAX_INPUTS + 1);

   localparam int WEIGHT_W = 16;
   localparam int ACC_W    = 40;
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 16;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   localparam int COUNT_W = 7;
   localparam int RATE_W  = 15;
   localparam int CSR_W   = 15;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [MUL_A_W-1:0]  mul_a_type;
   typedef logic signed [MUL_B_W-1:0]  mul_b_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [1:0]                 func_type;

   localparam idx_type BIAS_ADDR = idx_type'(MAX_INPUTS);

   localparam func_type FUNC_INFER = 2'd0;
   localparam func_type FUNC_LEARN = 2'd1;
   localparam func_type FUNC_WRITE = 2'd2;
   localparam func_type FUNC_NONE  = 2'd3;

   localparam logic CSR_ELEMENT_COUNT = 1'b0;
   localparam logic CSR_LEARN_RATE    = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 15'd410;

endpackage

`default_nettype wire

// ===== hdl/pdu_ram.sv =====
`default_nettype none

module pdu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pdu_mul.sv =====
`default_nettype none

// Shared signed multiplier, product registered.
module pdu_mul (
   input  logic               clock,
   input  pdu_pkg::mul_a_type mul_a,
   input  pdu_pkg::mul_b_type mul_b,
   output pdu_pkg::prod_type  prod
);

   pdu_pkg::prod_type prod_ff;
   pdu_pkg::prod_type prod_in;

   assign prod_in = pdu_pkg::prod_type'(mul_a) * pdu_pkg::prod_type'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/perceptron_dot_and_update.sv =====
// Write items and ignored items stay in idle, so the block is ready again the next cycle.
// Infer element: weight read, multiply, accumulate; the last element adds a bias step
// and its result is on rsp the cycle after that step, or once rsp frees up.
// Learn element: rate*error, step*element, weight write; the last element adds a bias write.
// Reset (synchronous, active high) clears index, accumulator, flags and config
// to defaults; the weight RAM is not cleared and must be written before use.
`default_nettype none

module perceptron_dot_and_update (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pdu_pkg::REQ_DATA_W-1:0]   req_tdata,  // value[15:0], error[31:16]
   input  logic [pdu_pkg::REQ_USER_W-1:0]   req_tuser,  // func[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pdu_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // sum[39:0]
   output logic [pdu_pkg::RSP_USER_W-1:0]   rsp_tuser,  // saturated[0]
   input  logic                             csr_wen,
   input  logic                             csr_index,
   input  logic [pdu_pkg::CSR_W-1:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_I_MUL  = 3'd1;
   localparam logic [2:0] ST_I_ACC  = 3'd2;
   localparam logic [2:0] ST_I_BIAS = 3'd3;
   localparam logic [2:0] ST_L_MUL  = 3'd4;
   localparam logic [2:0] ST_L_UPD  = 3'd5;
   localparam logic [2:0] ST_L_BIAS = 3'd6;

   function automatic pdu_pkg::weight_type sat_w(input logic signed [24:0] v);
      pdu_pkg::weight_type r;
      if (v > 25'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -25'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Registers
   logic [2:0]                          state_ff, state_in;
   logic [pdu_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [pdu_pkg::RATE_W-1:0]          rate_ff, rate_in;
   pdu_pkg::idx_type                    idx_ff, idx_in;
   pdu_pkg::func_type                   func_ff, func_in;
   pdu_pkg::acc_type                    acc_ff, acc_in;
   logic                                clip_ff, clip_in;
   logic                                last_ff, last_in;
   pdu_pkg::idx_type                    addr_ff, addr_in;
   pdu_pkg::weight_type                 x_ff, x_in;
   pdu_pkg::mul_a_type                  step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   pdu_pkg::acc_type                    rsp_sum_ff, rsp_sum_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   // Item decode
   pdu_pkg::func_type                   req_func;
   pdu_pkg::weight_type                 req_value;
   pdu_pkg::weight_type                 req_error;
   logic                                accept;
   logic                                func_new;
   pdu_pkg::idx_type                    n_eff;
   pdu_pkg::idx_type                    limit;
   pdu_pkg::idx_type                    idx_base;
   pdu_pkg::idx_type                    idx_cur;
   logic                                over_limit;
   logic                                is_last;
   pdu_pkg::idx_type                    addr_cur;

   // Datapath
   pdu_pkg::mul_a_type                  mul_a;
   pdu_pkg::mul_b_type                  mul_b;
   pdu_pkg::prod_type                   prod;
   logic                                ram_wr_en;
   pdu_pkg::idx_type                    ram_wr_addr;
   pdu_pkg::weight_type                 ram_wr_data;
   pdu_pkg::idx_type                    ram_rd_addr;
   logic [pdu_pkg::WEIGHT_W-1:0]        ram_rd_raw;
   pdu_pkg::weight_type                 ram_rd;
   logic signed [pdu_pkg::ACC_W:0]      acc_addend;
   logic signed [pdu_pkg::ACC_W:0]      acc_sum;
   logic                                acc_clip;
   pdu_pkg::acc_type                    acc_sat;
   pdu_pkg::prod_type                   dw_rnd;
   pdu_pkg::mul_a_type                  db_rnd;
   logic signed [24:0]                  w_diff;
   logic signed [24:0]                  b_diff;
   logic                                out_free;

   assign req_func  = req_tuser;
   assign req_value = req_tdata[15:0];
   assign req_error = req_tdata[31:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      if (count_ff == '0) begin
         n_eff = pdu_pkg::idx_type'(1);
      end else if (int'(count_ff) > pdu_pkg::MAX_INPUTS) begin
         n_eff = pdu_pkg::idx_type'(pdu_pkg::MAX_INPUTS);
      end else begin
         n_eff = pdu_pkg::idx_type'(count_ff);
      end
   end

   // Index handling for the item on the request port
   assign func_new   = (req_func != func_ff);
   assign limit      = (req_func == pdu_pkg::FUNC_WRITE) ? n_eff + 1'b1 : n_eff;
   assign idx_base   = func_new ? '0 : idx_ff;
   assign over_limit = (idx_base >= limit);
   assign idx_cur    = over_limit ? '0 : idx_base;
   assign is_last    = ({1'b0, idx_cur} + 1'b1) >= {1'b0, limit};
   assign addr_cur   = (req_func == pdu_pkg::FUNC_WRITE && idx_cur >= n_eff) ?
                       pdu_pkg::BIAS_ADDR : idx_cur;

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = pdu_pkg::mul_a_type'(rate_ff);
            mul_b = req_error;
         end
         ST_I_MUL: begin
            mul_a = pdu_pkg::mul_a_type'(ram_rd);
            mul_b = x_ff;
         end
         default: begin
            mul_a = prod[pdu_pkg::MUL_A_W-1:0];
            mul_b = x_ff;
         end
      endcase
   end

   pdu_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Weight RAM: registered read, the data follows the read address in the next cycle
   assign ram_rd = ram_rd_raw;

   always_comb begin
      case (state_ff)
         ST_IDLE:  ram_rd_addr = addr_cur;
         ST_L_MUL: ram_rd_addr = addr_ff;
         default:  ram_rd_addr = pdu_pkg::BIAS_ADDR;
      endcase
   end

   // Learn update: round to nearest, ties up, then saturate
   assign dw_rnd = prod + pdu_pkg::prod_type'(48'sd8388608);
   assign db_rnd = step_ff + 32'sd2048;
   assign w_diff = 25'(ram_rd) - 25'($signed(dw_rnd[pdu_pkg::PROD_W-1:24]));
   assign b_diff = 25'(ram_rd) - 25'($signed(db_rnd[pdu_pkg::MUL_A_W-1:12]));

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_cur;
      ram_wr_data = req_value;
      case (state_ff)
         ST_IDLE: begin
            ram_wr_en = accept && (req_func == pdu_pkg::FUNC_WRITE);
         end
         ST_L_UPD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = sat_w(w_diff);
         end
         ST_L_BIAS: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pdu_pkg::BIAS_ADDR;
            ram_wr_data = sat_w(b_diff);
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   pdu_ram #(
      .WIDTH (pdu_pkg::WEIGHT_W),
      .DEPTH (pdu_pkg::WEIGHT_DEPTH)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // Saturating accumulator: product in the accumulate step, bias*4096 after
   assign acc_addend = (state_ff == ST_I_ACC) ? prod[pdu_pkg::ACC_W:0] :
                       $signed({{13{ram_rd[15]}}, ram_rd, 12'b0});
   assign acc_sum    = $signed({acc_ff[pdu_pkg::ACC_W-1], acc_ff}) + acc_addend;
   assign acc_clip   = (acc_sum[pdu_pkg::ACC_W] != acc_sum[pdu_pkg::ACC_W-1]);
   assign acc_sat    = !acc_clip ? acc_sum[pdu_pkg::ACC_W-1:0] :
                       acc_sum[pdu_pkg::ACC_W] ? {1'b1, {(pdu_pkg::ACC_W-1){1'b0}}} :
                                                 {1'b0, {(pdu_pkg::ACC_W-1){1'b1}}};

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rate_in      = rate_ff;
      idx_in       = idx_ff;
      func_in      = func_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_wen) begin
         case (csr_index)
            pdu_pkg::CSR_ELEMENT_COUNT: count_in = csr_wdata[pdu_pkg::COUNT_W-1:0];
            pdu_pkg::CSR_LEARN_RATE:    rate_in  = csr_wdata[pdu_pkg::RATE_W-1:0];
            default:                    rate_in  = rate_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func != pdu_pkg::FUNC_NONE) begin
               func_in = req_func;
               idx_in  = is_last ? '0 : idx_cur + 1'b1;
               last_in = is_last;
               addr_in = addr_cur;
               x_in    = req_value;
               if (func_new || over_limit) begin
                  acc_in  = '0;
                  clip_in = 1'b0;
               end
               case (req_func)
                  pdu_pkg::FUNC_INFER: state_in = ST_I_MUL;
                  pdu_pkg::FUNC_LEARN: state_in = ST_L_MUL;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_I_MUL: begin
            state_in = ST_I_ACC;
         end
         ST_I_ACC: begin
            acc_in   = acc_sat;
            clip_in  = clip_ff || acc_clip;
            state_in = last_ff ? ST_I_BIAS : ST_IDLE;
         end
         ST_I_BIAS: begin
            // hold here until the output register can take the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_sat;
               rsp_sat_in   = clip_ff || acc_clip;
               acc_in       = '0;
               clip_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_L_MUL: begin
            step_in  = prod[pdu_pkg::MUL_A_W-1:0];
            state_in = ST_L_UPD;
         end
         ST_L_UPD: begin
            state_in = last_ff ? ST_L_BIAS : ST_IDLE;
         end
         ST_L_BIAS: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= pdu_pkg::COUNT_RESET;
         rate_ff      <= pdu_pkg::RATE_RESET;
         idx_ff       <= '0;
         func_ff      <= pdu_pkg::FUNC_INFER;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rate_ff      <= rate_in;
         idx_ff       <= idx_in;
         func_ff      <= func_in;
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      addr_ff    <= addr_in;
      x_ff       <= x_in;
      step_ff    <= step_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_sat_ff;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_idx_bound, idx_ff <= pdu_pkg::BIAS_ADDR, "element index past bias slot")
   `ASSERT_IMPL(a_rsp_from_bias, $rose(rsp_tvalid), $past(state_ff) == ST_I_BIAS, "result not from bias step")
   `ASSERT_NEXT(a_write_one_cycle, accept && req_func == pdu_pkg::FUNC_WRITE, state_ff == ST_IDLE, "write item not single cycle")
   `ASSERT_NEXT(a_bias_waits, state_ff == ST_I_BIAS && rsp_valid_ff && !rsp_tready, state_ff == ST_I_BIAS && $stable(rsp_tdata), "result overwrote pending transfer")

endmodule

`default_nettype wire

// ===== tb/perceptron_checker.sv =====
`default_nettype none

module perceptron_checker
   import pdu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // value[15:0], error[31:16]
   input  logic [REQ_USER_W-1:0] req_tuser,   // func[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // sum[39:0]
   input  logic [RSP_USER_W-1:0] rsp_tuser,   // saturated[0]
   input  logic                  csr_wen,
   input  logic                  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    sums_pending,
   output int                    mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint SUM_MIN = -(longint'(1) <<< (ACC_W - 1));

   typedef struct {
      acc_type sum;
      logic    saturated;
   } dot_result_type;

   dot_result_type       expected_sums[$];
   weight_type           weights[WEIGHT_DEPTH];
   longint               acc_value;
   logic                 clip_seen;
   int                   elem_idx;
   func_type             cur_func;
   logic [COUNT_W-1:0]   count_reg;
   logic [RATE_W-1:0]    rate_reg;
   int                   mismatches;

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic weight_type clamp16(longint v);
      if (v > 32767)
         return weight_type'(16'sh7fff);
      if (v < -32768)
         return weight_type'(16'sh8000);
      return weight_type'(v);
   endfunction

   task automatic clear_vector();
      elem_idx  = 0;
      acc_value = 0;
      clip_seen = 1'b0;
   endtask

   task automatic accumulate(longint term);
      longint r;
      r = acc_value + term;
      if (r > SUM_MAX) begin
         r = SUM_MAX;
         clip_seen = 1'b1;
      end else if (r < SUM_MIN) begin
         r = SUM_MIN;
         clip_seen = 1'b1;
      end
      acc_value = r;
   endtask

   task automatic predict_dot_item(func_type f, weight_type x, weight_type err);
      int             n;
      int             lim;
      int             i;
      logic           is_last;
      longint         step;
      dot_result_type res;
      if (f == FUNC_NONE)
         return;
      if (f != cur_func) begin
         clear_vector();
         cur_func = f;
      end
      n = (count_reg == 0) ? 1 : ((count_reg > MAX_INPUTS) ? MAX_INPUTS : int'(count_reg));
      lim = (f == FUNC_WRITE) ? n + 1 : n;
      if (elem_idx >= lim)
         clear_vector();
      i       = elem_idx;
      is_last = (i + 1 >= lim);
      case (f)
         FUNC_WRITE: begin
            weights[(i < n) ? i : MAX_INPUTS] = x;
            elem_idx = is_last ? 0 : i + 1;
         end
         FUNC_LEARN: begin
            step = longint'(rate_reg) * longint'(err);
            weights[i] = clamp16(longint'(weights[i]) - round_half_up(step * longint'(x), 24));
            if (is_last)
               weights[MAX_INPUTS] = clamp16(longint'(weights[MAX_INPUTS])
                                             - round_half_up(step, 12));
            elem_idx = is_last ? 0 : i + 1;
         end
         default: begin
            accumulate(longint'(weights[i]) * longint'(x));
            if (!is_last) begin
               elem_idx = i + 1;
            end else begin
               // bias is Q4.12, the sum Q16.24
               accumulate(longint'(weights[MAX_INPUTS]) * 4096);
               res.sum       = acc_type'(acc_value);
               res.saturated = clip_seen;
               expected_sums.push_back(res);
               clear_vector();
            end
         end
      endcase
   endtask

   task automatic check_dot_result(acc_type got_sum, logic got_sat);
      dot_result_type want;
      if (expected_sums.size() == 0) begin
         $display("%0t: unexpected result: expected none, got sum=%0d saturated=%0b",
                  $time, got_sum, got_sat);
         mismatches++;
         return;
      end
      want = expected_sums.pop_front();
      if (got_sum !== want.sum) begin
         $display("%0t: sum mismatch: expected %0d, got %0d", $time, want.sum, got_sum);
         mismatches++;
      end
      if (got_sat !== want.saturated) begin
         $display("%0t: saturated mismatch: expected %0b, got %0b",
                  $time, want.saturated, got_sat);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_vector();
         cur_func  = FUNC_INFER;
         count_reg = COUNT_RESET;
         rate_reg  = RATE_RESET;
         expected_sums.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_dot_result(acc_type'(rsp_tdata), rsp_tuser[0]);
         if (req_tvalid && req_tready)
            predict_dot_item(func_type'(req_tuser), weight_type'(req_tdata[15:0]),
                             weight_type'(req_tdata[31:16]));
         if (csr_wen) begin
            if (csr_index == CSR_ELEMENT_COUNT)
               count_reg = csr_wdata[COUNT_W-1:0];
            else
               rate_reg = csr_wdata[RATE_W-1:0];
         end
      end
      sums_pending   <= expected_sums.size();
      mismatch_count <= mismatches;
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdu_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int ITEM_TARGET   = 1680;
   localparam int SETTLE_CYCLES = 12;
   localparam int RSP_HOLD      = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wen;
   logic                  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   int   sums_pending;
   int   mismatch_count;
   int   items_sent;
   int   cur_len;
   int   grp_roll;
   logic sender_steady;
   logic long_hold_req;
   logic long_hold_done;
   logic receiver_steady;
   int   stall_left;

   perceptron_dot_and_update u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   perceptron_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sums_pending   (sums_pending),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'h8000;
      if (r < 20)
         return 16'h7fff;
      if (r < 25)
         return 16'h0000;
      return 16'($urandom);
   endfunction

   function automatic int vector_len(logic [COUNT_W-1:0] c);
      if (c == 0)
         return 1;
      if (c > MAX_INPUTS)
         return MAX_INPUTS;
      return int'(c);
   endfunction

   task automatic send_item(func_type f, logic [15:0] value, logic [15:0] err);
      int gap;
      gap = 0;
      if ($urandom_range(0, 63) == 0)
         sender_steady = ~sender_steady;
      if (!sender_steady && $urandom_range(0, 99) < 35)
         gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = REQ_DATA_W'($urandom);
         req_tuser  = REQ_USER_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = f;
      req_tdata  = {err, value};
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      if (f != FUNC_NONE)
         items_sent++;
   endtask

   // wait for every outstanding sum, then let the last learn or write drain
   task automatic settle();
      req_tvalid = 1'b0;
      while (sums_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] data);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wen   = 1'b0;
      csr_wdata = CSR_W'($urandom);
   endtask

   task automatic set_count(logic [CSR_W-1:0] data);
      write_csr(CSR_ELEMENT_COUNT, data);
      cur_len = vector_len(data[COUNT_W-1:0]);
   endtask

   task automatic run_vector(func_type f, int len);
      repeat (len) send_item(f, pick_value(), pick_value());
   endtask

   function automatic logic [CSR_W-1:0] pick_count();
      int                 r;
      logic [COUNT_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 60)
         c = COUNT_W'($urandom_range(1, 8));
      else if (r < 75)
         c = COUNT_W'($urandom_range(9, 31));
      else if (r < 83)
         c = COUNT_W'(MAX_INPUTS);
      else if (r < 88)
         c = '0;
      else if (r < 93)
         c = '1;
      else
         c = COUNT_W'($urandom_range(MAX_INPUTS + 1, 126));
      // upper bits are outside the count field
      return {8'($urandom), c};
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 20)
         return '1;
      if (r < 30)
         return RATE_RESET;
      if (r < 60)
         return RATE_W'($urandom_range(1, 1024));
      return RATE_W'($urandom);
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_INFER;
      csr_wen    = 1'b0;
      csr_index  = CSR_ELEMENT_COUNT;
      csr_wdata  = '0;
      items_sent = 0;
      cur_len    = vector_len(COUNT_RESET);
      sender_steady = 1'b0;
      long_hold_req = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // load every weight and the bias once so no later read sees an empty entry
      set_count(CSR_W'(MAX_INPUTS));
      run_vector(FUNC_WRITE, MAX_INPUTS + 1);

      settle();
      set_count(CSR_W'(2));
      write_csr(CSR_LEARN_RATE, '1);
      send_item(FUNC_INFER, 16'h7fff, 16'h8000);
      send_item(FUNC_INFER, 16'h8000, 16'h7fff);
      send_item(FUNC_LEARN, 16'h8000, 16'h8000);
      send_item(FUNC_LEARN, 16'h7fff, 16'h7fff);
      // ignored item in the middle of a vector
      send_item(FUNC_INFER, 16'h0000, 16'hffff);
      send_item(FUNC_NONE, 16'hffff, 16'hffff);
      send_item(FUNC_INFER, 16'h0001, 16'h0000);
      // func change mid-vector restarts the index
      send_item(FUNC_INFER, 16'h0005, 16'h0000);
      send_item(FUNC_LEARN, 16'hfff0, 16'h0123);
      send_item(FUNC_LEARN, 16'h7fff, 16'h8000);
      send_item(FUNC_WRITE, 16'h7fff, 16'h0000);
      send_item(FUNC_WRITE, 16'h8000, 16'hffff);
      send_item(FUNC_WRITE, 16'h8000, 16'h0000);
      send_item(FUNC_INFER, 16'h8000, 16'h0000);
      send_item(FUNC_INFER, 16'h8000, 16'h0000);

      // count shrinks while a vector is half done
      settle();
      set_count(CSR_W'(3));
      write_csr(CSR_LEARN_RATE, '0);
      send_item(FUNC_INFER, 16'h1234, 16'h0000);
      send_item(FUNC_INFER, 16'h8000, 16'h0000);
      settle();
      set_count(CSR_W'(1));
      send_item(FUNC_INFER, 16'h7fff, 16'h0000);
      send_item(FUNC_LEARN, 16'h7fff, 16'h8000);

      // zero count acts as one
      settle();
      set_count('0);
      write_csr(CSR_LEARN_RATE, RATE_RESET);
      send_item(FUNC_INFER, 16'h4000, 16'h0000);
      send_item(FUNC_LEARN, 16'h4000, 16'hc000);
      send_item(FUNC_INFER, 16'hc000, 16'h0000);

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         settle();
         if ($urandom_range(0, 3) != 0)
            set_count(pick_count());
         write_csr(CSR_LEARN_RATE, pick_rate());
         if (phase == 2) begin
            // receiver stalls a long stretch while infer vectors keep coming
            set_count(CSR_W'(2));
            long_hold_req = 1'b1;
            repeat (10) run_vector(FUNC_INFER, (cur_len > 6) ? 6 : cur_len);
         end
         repeat ($urandom_range(1, 8)) begin
            grp_roll = $urandom_range(0, 99);
            if (grp_roll < 45) begin
               run_vector(FUNC_INFER, cur_len);
            end else if (grp_roll < 70) begin
               run_vector(FUNC_LEARN, cur_len);
            end else if (grp_roll < 80) begin
               run_vector(FUNC_WRITE, cur_len + 1);
            end else begin
               repeat ($urandom_range(1, 4))
                  send_item(func_type'($urandom_range(0, 3)), pick_value(), pick_value());
            end
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      rsp_tready      = 1'b0;
      long_hold_done  = 1'b0;
      receiver_steady = 1'b0;
      stall_left      = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_tready = 1'b0;
            repeat (RSP_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
            rsp_tready     = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!receiver_steady && $urandom_range(0, 99) < 30)
               stall_left = pick_gap();
         end
         if ($urandom_range(0, 199) == 0)
            receiver_steady = ~receiver_steady;
      end
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/pdu_pkg.sv
hdl/pdu_ram.sv
hdl/pdu_mul.sv
hdl/perceptron_dot_and_update.sv
tb/perceptron_checker.sv
tb/tb.sv
